FILE: rtl/positional_array_sort_search_top_macros.svh
// Assertion helpers for the sorted array block
`ifndef POSITIONAL_ARRAY_SORT_SEARCH_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_SORT_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PASS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PASS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define PASS_ASSERT(lbl, clk, rst_n, prop)
`define PASS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/pass_pkg.sv
`timescale 1ns / 1ps
package pass_pkg;
  localparam int DEPTH = 128;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LO_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_SORT   = 3'd4;
  localparam logic [2:0] ACT_SEARCH = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_SORT = 5'b00100,
    S_SRCH = 5'b01000,
    S_DONE = 5'b10000
  } pass_state_e;

  typedef struct packed {
    logic rot;
    logic srt;
    logic phase;
  } pass_ctrl_t;
endpackage

FILE: rtl/pass_cell.sv
`timescale 1ns / 1ps
module pass_cell (
  input  logic                             clk_i,
  input  pass_pkg::pass_ctrl_t             ctrl_i,
  input  logic [pass_pkg::IDX_W-1:0]       idx_i,
  input  logic [pass_pkg::CNT_W-1:0]       count_i,
  input  logic [pass_pkg::DATA_WIDTH-1:0]  left_i,
  input  logic [pass_pkg::DATA_WIDTH-1:0]  right_i,
  input  logic [pass_pkg::DATA_WIDTH-1:0]  ring_i,
  output logic [pass_pkg::DATA_WIDTH-1:0]  value_o
);
  import pass_pkg::*;

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic pair_r, pair_l;

  assign pair_r = (idx_i[0] == ctrl_i.phase) &&
                  ((LO_W'(idx_i) + LO_W'(1)) < LO_W'(count_i));
  assign pair_l = (idx_i[0] != ctrl_i.phase) && (idx_i != '0) &&
                  (CNT_W'(idx_i) < count_i);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.rot) begin
      val_d = ring_i;
    end else if (ctrl_i.srt) begin
      if (pair_r && ($signed(right_i) < $signed(val_q))) begin
        val_d = right_i;
      end else if (pair_l && ($signed(val_q) < $signed(left_i))) begin
        val_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;
endmodule

FILE: rtl/positional_array_sort_search_top.sv
`timescale 1ns / 1ps
// Load, read, insert, delete: one full turn of the cell ring.
// Sort: DEPTH odd-even transposition passes.
// Search: sort, then one ring turn per probe.
// Rejected and unused actions go straight to the result with no ring turn. One transaction in work at a time.
// Reset clears the entry count and control; entry contents are not cleared.
`include "positional_array_sort_search_top_macros.svh"
module positional_array_sort_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic signed [31:0] item_value_i,
  input  logic [7:0]  position_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] result_value_o,
  output logic [6:0]  result_position_o,
  output logic [7:0]  entry_total_o
);
  import pass_pkg::*;

  logic [DATA_WIDTH-1:0] vals [DEPTH];
  logic [DATA_WIDTH-1:0] ring_in;
  pass_ctrl_t ctrl;

  pass_state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [IDX_W-1:0] t_q, t_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, tgt_q, tgt_d;
  logic [CMP_W-1:0] pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d, carry_q, carry_d, rval_q, rval_d;
  logic [2:0] status_q, status_d;
  logic [6:0] rpos_q, rpos_d;
  logic signed [LO_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic eq_q, eq_d, lt_q, lt_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] ostat_q, ostat_d;
  logic [31:0] oval_q, oval_d;
  logic [6:0] opos_q, opos_d;
  logic [7:0] otot_q, otot_d;

  logic accept, t_last, empty_srch;
  logic [LO_W:0] mid_sum;
  logic [IDX_W-1:0] mid;
  logic [CMP_W-1:0] t_w, cnt_w, pos_in;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign t_last = (t_q == IDX_W'(DEPTH - 1));
  assign mid_sum = (LO_W + 1)'(unsigned'(lo_q)) + (LO_W + 1)'(unsigned'(hi_q));
  assign mid = mid_sum[IDX_W:1];
  assign empty_srch = (t_q == '0) && (lo_q > hi_q);
  assign t_w = CMP_W'(t_q);
  assign cnt_w = CMP_W'(cnt_q);
  assign pos_in = CMP_W'(position_i);

  assign ctrl.rot = (state_q == S_ROT) || ((state_q == S_SRCH) && !empty_srch);
  assign ctrl.srt = (state_q == S_SORT);
  assign ctrl.phase = t_q[0];

  always_comb begin
    ring_in = vals[0];
    case (op_q)
      ACT_LOAD: begin
        if (CNT_W'(t_q) == tgt_q) ring_in = val_q;
      end
      ACT_INSERT: begin
        if (t_w == pos_q) ring_in = val_q;
        else if (t_w > pos_q) ring_in = carry_q;
      end
      ACT_DELETE: begin
        if (t_w >= pos_q) ring_in = vals[1];
      end
      default: ring_in = vals[0];
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v, right_v, ring_v;
    if (g == 0) begin : g_first
      assign left_v = vals[0];
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = vals[g];
      assign ring_v = ring_in;
    end else begin : g_mid_r
      assign right_v = vals[g+1];
      assign ring_v = vals[g+1];
    end
    pass_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .count_i (cnt_q),
      .left_i  (left_v),
      .right_i (right_v),
      .ring_i  (ring_v),
      .value_o (vals[g])
    );
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    t_d = t_q;
    cnt_d = cnt_q;
    tgt_d = tgt_q;
    pos_d = pos_q;
    val_d = val_q;
    carry_d = carry_q;
    rval_d = rval_q;
    status_d = status_q;
    rpos_d = rpos_q;
    lo_d = lo_q;
    hi_d = hi_q;
    eq_d = eq_q;
    lt_d = lt_q;
    out_valid_d = out_valid_q;
    ostat_d = ostat_q;
    oval_d = oval_q;
    opos_d = opos_q;
    otot_d = otot_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = action_i;
          pos_d = pos_in;
          val_d = DATA_WIDTH'(item_value_i);
          t_d = '0;
          status_d = ST_OK;
          rval_d = '0;
          rpos_d = '0;
          eq_d = 1'b0;
          lt_d = 1'b0;
          state_d = S_DONE;
          case (action_i)
            ACT_LOAD: begin
              if (!restart_i && (cnt_q == CNT_W'(DEPTH))) begin
                status_d = ST_FULL;
              end else begin
                tgt_d = restart_i ? '0 : cnt_q;
                state_d = S_ROT;
              end
            end
            ACT_READ, ACT_DELETE: begin
              if (cnt_q == '0) status_d = ST_EMPTY;
              else if (pos_in >= cnt_w) status_d = ST_BADPOS;
              else state_d = S_ROT;
            end
            ACT_INSERT: begin
              if (cnt_q == '0) status_d = ST_EMPTY;
              else if (cnt_q == CNT_W'(DEPTH)) status_d = ST_FULL;
              else if (pos_in > cnt_w) status_d = ST_BADPOS;
              else state_d = S_ROT;
            end
            ACT_SORT, ACT_SEARCH: state_d = S_SORT;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ROT: begin
        t_d = t_last ? '0 : t_q + IDX_W'(1);
        if (op_q == ACT_INSERT) carry_d = vals[0];
        if (((op_q == ACT_READ) || (op_q == ACT_DELETE)) && (t_w == pos_q)) begin
          rval_d = vals[0];
        end
        if (t_last) begin
          state_d = S_DONE;
          case (op_q)
            ACT_LOAD:   cnt_d = tgt_q + CNT_W'(1);
            ACT_INSERT: cnt_d = cnt_q + CNT_W'(1);
            ACT_DELETE: cnt_d = cnt_q - CNT_W'(1);
            default:    cnt_d = cnt_q;
          endcase
        end
      end
      S_SORT: begin
        t_d = t_last ? '0 : t_q + IDX_W'(1);
        if (t_last) begin
          if (op_q == ACT_SEARCH) begin
            lo_d = '0;
            hi_d = LO_W'(cnt_q) - LO_W'(1);
            state_d = S_SRCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SRCH: begin
        if (empty_srch) begin
          status_d = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          t_d = t_last ? '0 : t_q + IDX_W'(1);
          if (t_q == mid) begin
            eq_d = (vals[0] == val_q);
            lt_d = ($signed(vals[0]) < $signed(val_q));
          end
          if (t_last) begin
            if (eq_d) begin
              rpos_d = 7'(mid);
              state_d = S_DONE;
            end else if (lt_d) begin
              lo_d = LO_W'(mid) + LO_W'(1);
            end else begin
              hi_d = LO_W'(mid) - LO_W'(1);
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ostat_d = status_q;
          oval_d = 32'(signed'(rval_q));
          opos_d = rpos_q;
          otot_d = 8'(cnt_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      op_q <= ACT_LOAD;
      t_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      op_q <= op_d;
      t_q <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    pos_q <= pos_d;
    val_q <= val_d;
    carry_q <= carry_d;
    rval_q <= rval_d;
    status_q <= status_d;
    rpos_q <= rpos_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    eq_q <= eq_d;
    lt_q <= lt_d;
    ostat_q <= ostat_d;
    oval_q <= oval_d;
    opos_q <= opos_d;
    otot_q <= otot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = ostat_q;
  assign result_value_o = oval_q;
  assign result_position_o = opos_q;
  assign entry_total_o = otot_q;

  `PASS_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(DEPTH))
  `PASS_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> (state_q != S_IDLE))
  `PASS_ASSERT(a_cnt_on_turn, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> $past(state_q == S_ROT))
  `PASS_ASSERT(a_found_in_range, clk_i, rst_ni, ((state_q == S_DONE) && (op_q == ACT_SEARCH) && (status_q == ST_OK)) |-> (CNT_W'(rpos_q) < cnt_q))
endmodule
